[hdl/mfb_pkg.sv]
package mfb_pkg;

    // Frame store geometry
    localparam int unsigned DEF_STORE_WORDS = 8192;
    localparam int unsigned WORD_W          = 32;
    // Linear word index before wrap: 11-bit line times 9-bit pitch plus column word
    localparam int unsigned LIN_W           = 20;

    // Configuration port
    localparam int unsigned CFG_W     = 12;
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WORDS_PER_LINE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BITS     = 2'd2;

    localparam logic [8:0]  RST_WORDS_PER_LINE = 9'd16;
    localparam logic [11:0] RST_DISPLAY_HEIGHT = 12'd342;
    localparam logic [5:0]  RST_PIXEL_BITS     = 6'd1;

    // Operation selector carried in tuser
    localparam logic [1:0] FUNC_READ    = 2'd0;
    localparam logic [1:0] FUNC_MASKED  = 2'd1;
    localparam logic [1:0] FUNC_ALIGNED = 2'd2;
    localparam logic [1:0] FUNC_NONE    = 2'd3;

    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    // Row geometry handed to the merge logic
    typedef struct packed {
        logic [6:0] span;    // row width plus bit offset in the first word, 1..63
        logic [5:0] width;   // clamped row width, 1..32
        logic       invert;
    } row_ctl_t;

    // One result word
    typedef struct packed {
        logic              clipped;
        logic [WORD_W-1:0] read_bits;
    } result_t;

endpackage

[hdl/mfb_store.sv]
module mfb_store
    import mfb_pkg::*;
#(
    parameter int unsigned STORE_WORDS = DEF_STORE_WORDS
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic                           we,
    input  logic [$clog2(STORE_WORDS)-1:0] addr,
    input  logic [WORD_W-1:0]              wdata,
    output logic [WORD_W-1:0]              rdata
);

    logic [WORD_W-1:0] mem [STORE_WORDS];
    logic [WORD_W-1:0] rdata_reg;

    // Single port; read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/mfb_merge.sv]
module mfb_merge
    import mfb_pkg::*;
(
    input  row_ctl_t          ctl,
    input  logic [WORD_W-1:0] word0,
    input  logic [WORD_W-1:0] word1,
    input  logic [WORD_W-1:0] data,
    input  logic [WORD_W-1:0] mask,
    output logic [WORD_W-1:0] read_bits,
    output logic [WORD_W-1:0] new0,
    output logic [WORD_W-1:0] new1
);

    logic [6:0]          shamt7;
    logic [5:0]          shamt;
    logic [WORD_W-1:0]   cont;
    logic [WORD_W-1:0]   rev;
    logic [WORD_W-1:0]   d_word;
    logic [WORD_W-1:0]   m_word;
    logic [2*WORD_W-1:0] rd_wide;
    logic [2*WORD_W-1:0] d_wide;
    logic [2*WORD_W-1:0] m_wide;

    // Both words as one 64-bit line; the row ends (64 - span) bits from its low end
    assign shamt7 = 7'd64 - ctl.span;
    assign shamt  = shamt7[5:0];

    // Container by row width
    always_comb
    begin
        priority if (ctl.width <= 6'd8)
        begin
            cont = 32'h0000_00ff;
        end
        else if (ctl.width <= 6'd16)
        begin
            cont = 32'h0000_ffff;
        end
        else
        begin
            cont = ALL_ONES;
        end
    end

    // Read: right-align the row
    assign rd_wide   = {word0, word1} >> shamt;
    assign read_bits = rd_wide[WORD_W-1:0] & cont;

    // Masked write: clear masked bits, then OR the data in
    assign rev    = ctl.invert ? (ALL_ONES >> (6'd32 - ctl.width)) : '0;
    assign d_word = (data & cont) ^ rev;
    assign m_word = mask & cont;
    assign d_wide = {{WORD_W{1'b0}}, d_word} << shamt;
    assign m_wide = {{WORD_W{1'b0}}, m_word} << shamt;

    assign new0 = (word0 & ~m_wide[2*WORD_W-1:WORD_W]) | d_wide[2*WORD_W-1:WORD_W];
    assign new1 = (word1 & ~m_wide[WORD_W-1:0]) | d_wide[WORD_W-1:0];

endmodule

[hdl/mono_framebuffer_row_blitter.sv]
// Channel   Dir  Fields (lowest bit up)
// cfg_*     in   cfg_index 0 words_per_line, 1 display_height, 2 pixel_bits
// s_*       in   tuser: func; tdata: x_pos, y_pos, row_width, row_data, row_mask, invert
// m_*       out  tdata: read_bits; tuser: clipped
//
// One row at a time. A dropped row (clipped, unused func, read at wrong depth,
// narrow aligned write) ends in S_QUOT, an aligned write in S_FETCH, a one-word
// read or masked write in S_USE0, a read across two words in S_USE1 and a
// masked write across two words in S_WR1. S_QUOT and S_ADDR reduce the line
// address modulo store depth; the single-port store does one read or write per cycle.
// Reset sets the configuration registers to their defaults; the frame store is not cleared.
// A held result stays in the output register; one more finished result waits
// behind it, and no new row is taken until that slot is free.
module mono_framebuffer_row_blitter
    import mfb_pkg::*;
#(
    parameter int unsigned STORE_WORDS = DEF_STORE_WORDS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [95:0]          s_tdata,   // x_pos, y_pos, row_width, row_data, row_mask, invert
    input  logic [1:0]           s_tuser,   // func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // read_bits
    output logic [0:0]           m_tuser    // clipped
);

    localparam int unsigned AW = $clog2(STORE_WORDS);
    localparam logic [LIN_W:0]  N_L     = (LIN_W+1)'(STORE_WORDS);
    localparam logic [LIN_W:0]  RECIP_L = (LIN_W+1)'((1 << LIN_W) / STORE_WORDS);
    localparam logic [AW-1:0]   LAST    = AW'(STORE_WORDS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_QUOT  = 3'd1;
    localparam logic [2:0] S_ADDR  = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_USE0  = 3'd4;
    localparam logic [2:0] S_USE1  = 3'd5;
    localparam logic [2:0] S_WR1   = 3'd6;

    localparam logic [1:0] K_NOP     = 2'd0;
    localparam logic [1:0] K_READ    = 2'd1;
    localparam logic [1:0] K_MASKED  = 2'd2;
    localparam logic [1:0] K_ALIGNED = 2'd3;

    // Configuration registers
    logic [8:0]  wpl_reg;
    logic [11:0] height_reg;
    logic [5:0]  pbits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpl_reg    <= RST_WORDS_PER_LINE;
            height_reg <= RST_DISPLAY_HEIGHT;
            pbits_reg  <= RST_PIXEL_BITS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WORDS_PER_LINE: wpl_reg    <= cfg_wdata[8:0];
                CFG_DISPLAY_HEIGHT: height_reg <= cfg_wdata[11:0];
                CFG_PIXEL_BITS:     pbits_reg  <= cfg_wdata[5:0];
                default:            ;
            endcase
        end
    end

    // Input word unpacking
    logic [1:0]        in_func;
    logic [12:0]       in_x;
    logic [10:0]       in_y;
    logic [5:0]        in_w;
    logic [5:0]        w_eff;
    logic              in_clip;
    logic [1:0]        in_kind;
    logic [LIN_W-1:0]  in_lin;

    assign in_func = s_tuser;
    assign in_x    = s_tdata[12:0];
    assign in_y    = s_tdata[23:13];
    assign in_w    = s_tdata[29:24];
    assign in_clip = ({1'b0, in_y} >= height_reg);
    assign in_lin  = (LIN_W'(in_y) * LIN_W'(wpl_reg)) + LIN_W'(in_x[12:5]);

    always_comb
    begin
        priority if (in_w == 6'd0)
        begin
            w_eff = 6'd1;
        end
        else if (in_w > 6'd32)
        begin
            w_eff = 6'd32;
        end
        else
        begin
            w_eff = in_w;
        end
    end

    // Decide what the row needs from the store
    always_comb
    begin
        priority if (in_func == FUNC_NONE || in_clip)
        begin
            in_kind = K_NOP;
        end
        else if (in_func == FUNC_READ)
        begin
            in_kind = (pbits_reg == 6'd1) ? K_READ : K_NOP;
        end
        else if (in_func == FUNC_MASKED)
        begin
            in_kind = K_MASKED;
        end
        else
        begin
            in_kind = (w_eff == 6'd32) ? K_ALIGNED : K_NOP;
        end
    end

    // Row held for the duration of the item
    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [1:0]        kind_reg;
    logic              clip_reg;
    logic              straddle_reg;
    row_ctl_t          ctl_reg;
    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] mask_reg;
    logic [LIN_W-1:0]  lin_reg;
    logic [LIN_W-1:0]  q_reg;
    logic [AW-1:0]     a0_reg;
    logic [WORD_W-1:0] word0_reg;
    logic [WORD_W-1:0] rd_data;
    logic              accept;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg       <= in_kind;
            clip_reg       <= (in_func != FUNC_NONE) && in_clip;
            straddle_reg   <= ({1'b0, w_eff} + 7'(in_x[4:0])) > 7'd32;
            ctl_reg.span   <= {1'b0, w_eff} + 7'(in_x[4:0]);
            ctl_reg.width  <= w_eff;
            ctl_reg.invert <= s_tdata[94];
            data_reg       <= s_tdata[61:30];
            mask_reg       <= s_tdata[93:62];
            lin_reg        <= in_lin;
        end
    end

    // Wrap modulo store depth: reciprocal estimate, then one correction
    logic [2*LIN_W:0] quot_prod;
    logic [2*LIN_W:0] qn_prod;
    logic [LIN_W-1:0] r_raw;
    logic [LIN_W:0]   r_fix;
    logic [AW-1:0]    a1;

    assign quot_prod = {{(LIN_W+1){1'b0}}, lin_reg} * {{LIN_W{1'b0}}, RECIP_L};
    assign qn_prod   = {{(LIN_W+1){1'b0}}, q_reg} * {{LIN_W{1'b0}}, N_L};
    assign r_raw     = lin_reg - qn_prod[LIN_W-1:0];
    assign r_fix     = ({1'b0, r_raw} >= N_L) ? ({1'b0, r_raw} - N_L) : {1'b0, r_raw};
    assign a1        = (a0_reg == LAST) ? '0 : (a0_reg + AW'(1));

    always_ff @(posedge clk)
    begin
        if (state_reg == S_QUOT)
        begin
            q_reg <= quot_prod[2*LIN_W-1:LIN_W];
        end
        if (state_reg == S_ADDR)
        begin
            a0_reg <= r_fix[AW-1:0];
        end
        if (state_reg == S_USE0)
        begin
            word0_reg <= rd_data;
        end
    end

    // Frame store and merge
    logic              mem_en;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mg_w0;
    logic [WORD_W-1:0] mg_read;
    logic [WORD_W-1:0] mg_new0;
    logic [WORD_W-1:0] mg_new1;

    mfb_store #(
        .STORE_WORDS (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (rd_data)
    );

    assign mg_w0 = (state_reg == S_USE0) ? rd_data : word0_reg;

    mfb_merge u_merge (
        .ctl       (ctl_reg),
        .word0     (mg_w0),
        .word1     (rd_data),
        .data      (data_reg),
        .mask      (mask_reg),
        .read_bits (mg_read),
        .new0      (mg_new0),
        .new1      (mg_new1)
    );

    // Sequencer
    logic    fin;
    result_t fin_res;

    always_comb
    begin
        state_next = state_reg;
        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = a0_reg;
        mem_wdata  = mg_new0;
        fin        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_QUOT;
                end
            end
            S_QUOT:
            begin
                if (kind_reg == K_NOP)
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                mem_en = 1'b1;
                if (kind_reg == K_ALIGNED)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = ctl_reg.invert ? ~data_reg : data_reg;
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_USE0;
                end
            end
            S_USE0:
            begin
                if (straddle_reg)
                begin
                    mem_en     = 1'b1;
                    mem_addr   = a1;
                    state_next = S_USE1;
                end
                else
                begin
                    mem_en     = (kind_reg == K_MASKED);
                    mem_we     = (kind_reg == K_MASKED);
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_USE1:
            begin
                if (kind_reg == K_MASKED)
                begin
                    mem_en     = 1'b1;
                    mem_we     = 1'b1;
                    state_next = S_WR1;
                end
                else
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WR1:
            begin
                mem_en     = 1'b1;
                mem_we     = 1'b1;
                mem_addr   = a1;
                mem_wdata  = mg_new1;
                fin        = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign fin_res.clipped   = clip_reg;
    assign fin_res.read_bits = (kind_reg == K_READ) ? mg_read : '0;

    // Output register with one waiting slot behind it
    logic    out_valid_reg;
    result_t out_reg;
    logic    pend_valid_reg;
    result_t pend_reg;
    logic    out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= fin;
            end
            else
            begin
                out_valid_reg <= fin;
            end
        end
        else if (fin)
        begin
            pend_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_reg <= pend_reg;
                if (fin)
                begin
                    pend_reg <= fin_res;
                end
            end
            else if (fin)
            begin
                out_reg <= fin_res;
            end
        end
        else if (fin)
        begin
            pend_reg <= fin_res;
        end
    end

    assign s_tready = (state_reg == S_IDLE) && !pend_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.read_bits;
    assign m_tuser  = out_reg.clipped;

    // Checks
    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("waiting result without a result in the output register");

    a_fin_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        fin |-> !pend_valid_reg)
        else $error("result finished with both output slots full");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_QUOT)
        else $error("accepted row did not start address reduction");

    a_addr_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FETCH |-> a0_reg <= LAST)
        else $error("frame store address beyond store depth");

    a_second_word_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WR1 |-> $past(state_reg) == S_USE1 && $past(mem_we))
        else $error("second word written without first word write");

endmodule
